// ===== hw/rtl/msi_pkg.sv =====
package msi_pkg;

	// event kinds
	localparam logic [2:0] FUNC_EVAL         = 3'd0;
	localparam logic [2:0] FUNC_OVERRUN      = 3'd1;
	localparam logic [2:0] FUNC_ON_TIME      = 3'd2;
	localparam logic [2:0] FUNC_BEGIN_TRIAL  = 3'd3;
	localparam logic [2:0] FUNC_CLEAR_FAULT  = 3'd4;

	// stop reasons
	localparam logic [2:0] REASON_NONE        = 3'd0;
	localparam logic [2:0] REASON_BOOT        = 3'd1;
	localparam logic [2:0] REASON_PARAM_ERROR = 3'd2;
	localparam logic [2:0] REASON_LINE_LOST   = 3'd3;
	localparam logic [2:0] REASON_LEFT_STALL  = 3'd4;
	localparam logic [2:0] REASON_RIGHT_STALL = 3'd5;
	localparam logic [2:0] REASON_OVERRUN     = 3'd6;

	// fault codes
	localparam logic [2:0] FLT_CLEAR       = 3'd0;
	localparam logic [2:0] FLT_LOGIC       = 3'd1;
	localparam logic [2:0] FLT_NO_LINE     = 3'd2;
	localparam logic [2:0] FLT_LEFT_STALL  = 3'd3;
	localparam logic [2:0] FLT_RIGHT_STALL = 3'd4;
	localparam logic [2:0] FLT_OVERRUN     = 3'd5;

	// register indexes (byte address 4*index)
	localparam logic [2:0] REG_STALL_PWM   = 3'd0;
	localparam logic [2:0] REG_STALL_SPEED = 3'd1;
	localparam logic [2:0] REG_OVERRUN_LIM = 3'd2;
	localparam logic [2:0] REG_LINE_LIM    = 3'd3;
	localparam logic [2:0] REG_STALL_LIM   = 3'd4;

	localparam int ADDR_W = 5;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [2:0]         func;
		logic [31:0]        tick;
		logic               params_valid;
		logic               require_line;
		logic               line_valid;
		logic signed [15:0] left_pwm;
		logic signed [15:0] left_speed;
		logic signed [15:0] right_pwm;
		logic signed [15:0] right_speed;
		logic [15:0]        missed_ticks;
	} in_item_t;

	typedef struct packed {
		logic        stop_fired;
		logic        stop_pulse;
		logic [2:0]  stop_reason;
		logic [2:0]  fault_code;
		logic [31:0] stop_tick;
		logic [15:0] line_lost_count;
		logic [15:0] left_stall_count;
		logic [15:0] right_stall_count;
		logic [15:0] overrun_count;
	} out_item_t;

	typedef struct packed {
		logic [14:0] stall_pwm_threshold;
		logic [14:0] stall_speed_threshold;
		logic [15:0] overrun_limit;
		logic [15:0] line_lost_limit;
		logic [15:0] stall_limit;
	} cfg_t;

	typedef struct packed {
		logic [15:0] line_lost_ticks;
		logic [15:0] left_stall_ticks;
		logic [15:0] right_stall_ticks;
		logic [15:0] overrun_total;
		logic [2:0]  latched_reason;
		logic [2:0]  latched_fault;
		logic [31:0] latched_tick;
	} state_t;

	localparam cfg_t CFG_RESET = '{
		stall_pwm_threshold:   15'd0,
		stall_speed_threshold: 15'd0,
		overrun_limit:         16'd3,
		line_lost_limit:       16'd150,
		stall_limit:           16'd300
	};

	localparam state_t STATE_RESET = '{
		line_lost_ticks:   16'd0,
		left_stall_ticks:  16'd0,
		right_stall_ticks: 16'd0,
		overrun_total:     16'd0,
		latched_reason:    REASON_BOOT,
		latched_fault:     FLT_CLEAR,
		latched_tick:      32'd0
	};

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == CNT_MAX) ? v : v + 16'd1;
	endfunction

	// |v| with -32768 giving 32768
	function automatic logic [15:0] mag16(input logic [15:0] v);
		return v[15] ? (~v + 16'd1) : v;
	endfunction

endpackage

// ===== hw/rtl/msi_eval.sv =====
module msi_eval (
	input  msi_pkg::in_item_t  item,
	input  msi_pkg::state_t    st,
	input  msi_pkg::cfg_t      cfg,
	output msi_pkg::state_t    st_next,
	output msi_pkg::out_item_t res
);

	logic        left_stall;
	logic        right_stall;
	logic [15:0] line_cnt;
	logic [16:0] over_sum;
	logic [15:0] over_cnt;
	logic        fired;
	logic        pulse;

	always_comb begin
		left_stall  = (msi_pkg::mag16(item.left_pwm) > {1'b0, cfg.stall_pwm_threshold})
			&& (msi_pkg::mag16(item.left_speed) < {1'b0, cfg.stall_speed_threshold});
		right_stall = (msi_pkg::mag16(item.right_pwm) > {1'b0, cfg.stall_pwm_threshold})
			&& (msi_pkg::mag16(item.right_speed) < {1'b0, cfg.stall_speed_threshold});
		line_cnt = item.line_valid ? 16'd0 : msi_pkg::sat_inc(st.line_lost_ticks);
		over_sum = {1'b0, st.overrun_total} + {1'b0, item.missed_ticks};
		over_cnt = over_sum[16] ? msi_pkg::CNT_MAX : over_sum[15:0];
	end

	always_comb begin
		st_next = st;
		fired   = 1'b0;
		pulse   = 1'b0;
		case (item.func)
			msi_pkg::FUNC_EVAL: begin
				if (!item.params_valid) begin
					st_next.latched_reason = msi_pkg::REASON_PARAM_ERROR;
					st_next.latched_fault  = msi_pkg::FLT_LOGIC;
					st_next.latched_tick   = item.tick;
					fired = 1'b1;
				end else if (item.require_line && line_cnt >= cfg.line_lost_limit) begin
					// line check fires first; stall counters untouched
					st_next.line_lost_ticks = line_cnt;
					st_next.latched_reason  = msi_pkg::REASON_LINE_LOST;
					st_next.latched_fault   = msi_pkg::FLT_NO_LINE;
					st_next.latched_tick    = item.tick;
					fired = 1'b1;
				end else begin
					st_next.line_lost_ticks   = item.require_line ? line_cnt : 16'd0;
					st_next.left_stall_ticks  = left_stall ?
						msi_pkg::sat_inc(st.left_stall_ticks) : 16'd0;
					st_next.right_stall_ticks = right_stall ?
						msi_pkg::sat_inc(st.right_stall_ticks) : 16'd0;
					if (st_next.left_stall_ticks >= cfg.stall_limit) begin
						st_next.latched_reason = msi_pkg::REASON_LEFT_STALL;
						st_next.latched_fault  = msi_pkg::FLT_LEFT_STALL;
						st_next.latched_tick   = item.tick;
						fired = 1'b1;
					end else if (st_next.right_stall_ticks >= cfg.stall_limit) begin
						st_next.latched_reason = msi_pkg::REASON_RIGHT_STALL;
						st_next.latched_fault  = msi_pkg::FLT_RIGHT_STALL;
						st_next.latched_tick   = item.tick;
						fired = 1'b1;
					end
				end
			end
			msi_pkg::FUNC_OVERRUN: begin
				if (item.params_valid && item.missed_ticks != 16'd0) begin
					st_next.overrun_total = over_cnt;
					if (over_cnt >= cfg.overrun_limit) begin
						st_next.latched_reason = msi_pkg::REASON_OVERRUN;
						st_next.latched_fault  = msi_pkg::FLT_OVERRUN;
						st_next.latched_tick   = item.tick;
						fired = 1'b1;
					end
				end
			end
			msi_pkg::FUNC_ON_TIME: begin
				st_next.overrun_total = 16'd0;
			end
			msi_pkg::FUNC_BEGIN_TRIAL, msi_pkg::FUNC_CLEAR_FAULT: begin
				st_next.line_lost_ticks   = 16'd0;
				st_next.left_stall_ticks  = 16'd0;
				st_next.right_stall_ticks = 16'd0;
				st_next.overrun_total     = 16'd0;
				st_next.latched_reason    = msi_pkg::REASON_NONE;
				st_next.latched_fault     = msi_pkg::FLT_CLEAR;
				st_next.latched_tick      = item.tick;
				pulse = (item.func == msi_pkg::FUNC_CLEAR_FAULT);
			end
			default: begin
			end
		endcase

		res.stop_fired        = fired;
		res.stop_pulse        = fired | pulse;
		res.stop_reason       = st_next.latched_reason;
		res.fault_code        = st_next.latched_fault;
		res.stop_tick         = st_next.latched_tick;
		res.line_lost_count   = st_next.line_lost_ticks;
		res.left_stall_count  = st_next.left_stall_ticks;
		res.right_stall_count = st_next.right_stall_ticks;
		res.overrun_count     = st_next.overrun_total;
	end

endmodule

// ===== hw/rtl/motor_safety_interlock.sv =====
// Safety interlock for a two-motor line follower.
// in channel (in_valid/in_ready/in_item): one event per item, selected by func:
// evaluate a control sample, report missed ticks, on-time tick, begin trial,
// clear fault. out channel (out_valid/out_ready/out_item): exactly one result
// per event, showing the interlock state after that event; stop_pulse is the
// one-item pulse to stop the motors and reset the controller.
// APB port: five 32-bit registers at 0x00..0x10 (stall PWM threshold, stall
// speed threshold, overrun limit, line-lost limit, stall limit); write only
// while no event is in flight. pready is tied high.
// Timing: an accepted item sits in the input register; its result is
// registered, with out_valid raised, once the result register is free or read.
// Throughput: one item per cycle while out_ready stays high; state update and
// result come from one pass of compare/saturating-add logic between registers.
// Reset: counters cleared, reason = boot, fault = none, stop tick = 0,
// registers to their defaults, both channels empty.
// Receiver stall: the result register holds; the input register takes one
// more item if it is empty, then in_ready drops until out_ready returns.
module motor_safety_interlock (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  msi_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output msi_pkg::out_item_t                  out_item,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [msi_pkg::ADDR_W-1:0]          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	msi_pkg::cfg_t      cfg_q;
	msi_pkg::state_t    st_q;
	msi_pkg::state_t    st_next;
	msi_pkg::in_item_t  item_s1;
	logic               valid_s1;
	msi_pkg::out_item_t res;
	logic               adv;
	logic               wr_en;
	logic [2:0]         reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[msi_pkg::ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= msi_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				msi_pkg::REG_STALL_PWM:   cfg_q.stall_pwm_threshold   <= pwdata[14:0];
				msi_pkg::REG_STALL_SPEED: cfg_q.stall_speed_threshold <= pwdata[14:0];
				msi_pkg::REG_OVERRUN_LIM: cfg_q.overrun_limit         <= pwdata[15:0];
				msi_pkg::REG_LINE_LIM:    cfg_q.line_lost_limit       <= pwdata[15:0];
				msi_pkg::REG_STALL_LIM:   cfg_q.stall_limit           <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			msi_pkg::REG_STALL_PWM:   prdata = {17'd0, cfg_q.stall_pwm_threshold};
			msi_pkg::REG_STALL_SPEED: prdata = {17'd0, cfg_q.stall_speed_threshold};
			msi_pkg::REG_OVERRUN_LIM: prdata = {16'd0, cfg_q.overrun_limit};
			msi_pkg::REG_LINE_LIM:    prdata = {16'd0, cfg_q.line_lost_limit};
			msi_pkg::REG_STALL_LIM:   prdata = {16'd0, cfg_q.stall_limit};
			default:                  prdata = 32'd0;
		endcase
	end

	// item moves from the input register into the result register
	assign adv      = valid_s1 & (~out_valid | out_ready);
	assign in_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
			st_q      <= msi_pkg::STATE_RESET;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv) begin
				out_valid <= 1'b1;
				st_q      <= st_next;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
		if (adv)
			out_item <= res;
	end

	msi_eval u_eval (
		.item    (item_s1),
		.st      (st_q),
		.cfg     (cfg_q),
		.st_next (st_next),
		.res     (res)
	);

endmodule

// ===== hw/rtl/msi_checker.sv =====
module msi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input msi_pkg::out_item_t out_item
);

	// a fired stop always pulses the motors
	a_fire_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.stop_fired |-> out_item.stop_pulse)
		else $error("stop fired without stop pulse");

	// every stop latches a matching fault (fault = reason - 1)
	a_fire_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.stop_fired |->
			({1'b0, out_item.fault_code} + 4'd1 == {1'b0, out_item.stop_reason}))
		else $error("stop reason and fault code disagree");

	// a pulse without a stop is a clear fault: reason, fault, overrun and line-lost cleared
	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.stop_pulse && !out_item.stop_fired |->
			out_item.stop_reason == msi_pkg::REASON_NONE
			&& out_item.fault_code == msi_pkg::FLT_CLEAR
			&& out_item.overrun_count == 16'd0
			&& out_item.line_lost_count == 16'd0)
		else $error("clear pulse with state not cleared");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result item changed");

endmodule

bind motor_safety_interlock msi_checker u_msi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

// ===== bench/tb_motor_safety_interlock.sv =====
module tb_motor_safety_interlock;
	timeunit 1ns;
	timeprecision 1ps;

	// func codes the block leaves unused
	localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
	localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 155;
	localparam int HOLD_PHASE      = 4;
	localparam int HOLD_CYCLES     = 60;
	localparam int TAIL_CYCLES     = 8;

	typedef struct {
		bit                 is_cfg;
		logic [2:0]         idx;
		logic [31:0]        val;
		msi_pkg::in_item_t  ev;
		bit                 known;
		msi_pkg::out_item_t fixed;
	} step_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	msi_pkg::in_item_t            in_item;
	logic                         out_valid;
	logic                         out_ready;
	msi_pkg::out_item_t           out_item;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [msi_pkg::ADDR_W-1:0]   paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	msi_pkg::cfg_t                limits;
	msi_pkg::state_t              track;
	msi_pkg::out_item_t           status_q[$];
	step_t                        plan[$];
	int                           fails;
	bit                           gaps_on;
	bit                           stalls_on;
	bit                           hold_pending;

	motor_safety_interlock dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- interlock predictor ----------------

	function automatic logic [15:0] bump(logic [15:0] v);
		return v + {15'd0, ~&v};
	endfunction

	function automatic bit stalled(logic [15:0] pwm, logic [15:0] speed);
		logic [15:0] pm;
		logic [15:0] sm;
		pm = pwm[15] ? 16'd0 - pwm : pwm;
		sm = speed[15] ? 16'd0 - speed : speed;
		return pm > {1'b0, limits.stall_pwm_threshold} &&
			sm < {1'b0, limits.stall_speed_threshold};
	endfunction

	function automatic void record_stop(logic [2:0] reason, logic [2:0] fault,
			logic [31:0] tick);
		track.latched_reason = reason;
		track.latched_fault  = fault;
		track.latched_tick   = tick;
	endfunction

	function automatic msi_pkg::out_item_t interlock_step(msi_pkg::in_item_t ev);
		msi_pkg::out_item_t r;
		logic               fired;
		logic [16:0]        sum;
		fired = 1'b0;
		case (ev.func)
		msi_pkg::FUNC_EVAL: begin
			if (!ev.params_valid) begin
				record_stop(msi_pkg::REASON_PARAM_ERROR, msi_pkg::FLT_LOGIC, ev.tick);
				fired = 1'b1;
			end else begin
				track.line_lost_ticks = (ev.require_line && !ev.line_valid) ?
					bump(track.line_lost_ticks) : 16'd0;
				if (ev.require_line && track.line_lost_ticks >= limits.line_lost_limit) begin
					record_stop(msi_pkg::REASON_LINE_LOST, msi_pkg::FLT_NO_LINE, ev.tick);
					fired = 1'b1;
				end else begin
					track.left_stall_ticks = stalled(ev.left_pwm, ev.left_speed) ?
						bump(track.left_stall_ticks) : 16'd0;
					track.right_stall_ticks = stalled(ev.right_pwm, ev.right_speed) ?
						bump(track.right_stall_ticks) : 16'd0;
					if (track.left_stall_ticks >= limits.stall_limit) begin
						record_stop(msi_pkg::REASON_LEFT_STALL, msi_pkg::FLT_LEFT_STALL,
							ev.tick);
						fired = 1'b1;
					end else if (track.right_stall_ticks >= limits.stall_limit) begin
						record_stop(msi_pkg::REASON_RIGHT_STALL, msi_pkg::FLT_RIGHT_STALL,
							ev.tick);
						fired = 1'b1;
					end
				end
			end
		end
		msi_pkg::FUNC_OVERRUN: begin
			if (ev.params_valid && ev.missed_ticks != 16'd0) begin
				sum = track.overrun_total + ev.missed_ticks;
				track.overrun_total = sum[16] ? 16'hFFFF : sum[15:0];
				if (track.overrun_total >= limits.overrun_limit) begin
					record_stop(msi_pkg::REASON_OVERRUN, msi_pkg::FLT_OVERRUN, ev.tick);
					fired = 1'b1;
				end
			end
		end
		msi_pkg::FUNC_ON_TIME: track.overrun_total = 16'd0;
		msi_pkg::FUNC_BEGIN_TRIAL, msi_pkg::FUNC_CLEAR_FAULT: begin
			track.line_lost_ticks   = 16'd0;
			track.left_stall_ticks  = 16'd0;
			track.right_stall_ticks = 16'd0;
			track.overrun_total     = 16'd0;
			record_stop(msi_pkg::REASON_NONE, msi_pkg::FLT_CLEAR, ev.tick);
		end
		default: ;
		endcase
		r.stop_fired        = fired;
		r.stop_pulse        = fired || ev.func == msi_pkg::FUNC_CLEAR_FAULT;
		r.stop_reason       = track.latched_reason;
		r.fault_code        = track.latched_fault;
		r.stop_tick         = track.latched_tick;
		r.line_lost_count   = track.line_lost_ticks;
		r.left_stall_count  = track.left_stall_ticks;
		r.right_stall_count = track.right_stall_ticks;
		r.overrun_count     = track.overrun_total;
		return r;
	endfunction

	// ---------------- checking ----------------

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	function automatic void check_status(msi_pkg::out_item_t want, msi_pkg::out_item_t got);
		check_field("stop_fired", want.stop_fired, got.stop_fired);
		check_field("stop_pulse", want.stop_pulse, got.stop_pulse);
		check_field("stop_reason", want.stop_reason, got.stop_reason);
		check_field("fault_code", want.fault_code, got.fault_code);
		check_field("stop_tick", want.stop_tick, got.stop_tick);
		check_field("line_lost_count", want.line_lost_count, got.line_lost_count);
		check_field("left_stall_count", want.left_stall_count, got.left_stall_count);
		check_field("right_stall_count", want.right_stall_count, got.right_stall_count);
		check_field("overrun_count", want.overrun_count, got.overrun_count);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (status_q.size() == 0) begin
				$error("status item with nothing expected");
				fails++;
			end else begin
				check_status(status_q.pop_front(), out_item);
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	function automatic msi_pkg::in_item_t evt(logic [2:0] f, logic [31:0] tick, bit pv,
			bit rl, bit lv, logic [15:0] lp, logic [15:0] ls, logic [15:0] rp,
			logic [15:0] rs, logic [15:0] mt);
		msi_pkg::in_item_t ev;
		ev.func         = f;
		ev.tick         = tick;
		ev.params_valid = pv;
		ev.require_line = rl;
		ev.line_valid   = lv;
		ev.left_pwm     = lp;
		ev.left_speed   = ls;
		ev.right_pwm    = rp;
		ev.right_speed  = rs;
		ev.missed_ticks = mt;
		return ev;
	endfunction

	function automatic msi_pkg::out_item_t status(bit fired, bit pulse, logic [2:0] reason,
			logic [2:0] fault, logic [31:0] tick, logic [15:0] llc, logic [15:0] lsc,
			logic [15:0] rsc, logic [15:0] oc);
		msi_pkg::out_item_t r;
		r.stop_fired        = fired;
		r.stop_pulse        = pulse;
		r.stop_reason       = reason;
		r.fault_code        = fault;
		r.stop_tick         = tick;
		r.line_lost_count   = llc;
		r.left_stall_count  = lsc;
		r.right_stall_count = rsc;
		r.overrun_count     = oc;
		return r;
	endfunction

	function automatic void add_ev(msi_pkg::in_item_t ev, bit known = 1'b0,
			msi_pkg::out_item_t fixed = '0);
		step_t s;
		s.is_cfg = 1'b0;
		s.idx    = '0;
		s.val    = '0;
		s.ev     = ev;
		s.known  = known;
		s.fixed  = fixed;
		plan.push_back(s);
	endfunction

	function automatic void add_reg(logic [2:0] idx, logic [31:0] val);
		step_t s;
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.val    = val;
		s.ev     = '0;
		s.known  = 1'b0;
		s.fixed  = '0;
		plan.push_back(s);
	endfunction

	// pwm/speed pair, mostly on the stall side of the current thresholds
	function automatic logic [31:0] drive_pair();
		int unsigned pm;
		int unsigned sm;
		int unsigned pt;
		int unsigned stt;
		logic [15:0] p;
		logic [15:0] s;
		pt  = limits.stall_pwm_threshold;
		stt = limits.stall_speed_threshold;
		case ($urandom_range(0, 5))
		0: return $urandom;
		1: begin
			pm = pt + $urandom_range(0, 1);
			sm = (stt == 0) ? 0 : stt - $urandom_range(0, 1);
		end
		default: begin
			pm = $urandom_range(pt + 1, 32768);
			sm = (stt == 0) ? 0 : $urandom_range(0, stt - 1);
		end
		endcase
		p = pm[15:0];
		s = sm[15:0];
		if ($urandom_range(0, 1)) p = 16'd0 - p;
		if ($urandom_range(0, 1)) s = 16'd0 - s;
		return {p, s};
	endfunction

	function automatic msi_pkg::in_item_t random_event();
		msi_pkg::in_item_t ev;
		logic [31:0]       r;
		logic [31:0]       pair;
		int unsigned       pick;
		r = $urandom;
		ev.tick         = $urandom;
		ev.params_valid = r[0];
		ev.require_line = r[1];
		ev.line_valid   = r[2];
		ev.func         = msi_pkg::FUNC_EVAL;
		r = $urandom;
		ev.left_pwm     = r[15:0];
		ev.left_speed   = r[31:16];
		r = $urandom;
		ev.right_pwm    = r[15:0];
		ev.right_speed  = r[31:16];
		r = $urandom;
		ev.missed_ticks = r[15:0];
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			ev.params_valid = ($urandom_range(0, 24) != 0);
			ev.require_line = ($urandom_range(0, 2) == 0);
			pair = drive_pair();
			ev.left_pwm    = pair[31:16];
			ev.left_speed  = pair[15:0];
			pair = drive_pair();
			ev.right_pwm   = pair[31:16];
			ev.right_speed = pair[15:0];
		end else if (pick < 70) begin
			ev.func = msi_pkg::FUNC_OVERRUN;
			ev.params_valid = ($urandom_range(0, 9) != 0);
			case ($urandom_range(0, 4))
			0: ev.missed_ticks = 16'd0;
			1: ev.missed_ticks = 16'hFFFF;
			2: ;
			default: begin
				r = $urandom_range(1, 4);
				ev.missed_ticks = r[15:0];
			end
			endcase
		end else if (pick < 78) begin
			ev.func = msi_pkg::FUNC_ON_TIME;
		end else if (pick < 85) begin
			ev.func = msi_pkg::FUNC_BEGIN_TRIAL;
		end else if (pick < 93) begin
			ev.func = msi_pkg::FUNC_CLEAR_FAULT;
		end else begin
			r = $urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI);
			ev.func = r[2:0];
		end
		return ev;
	endfunction

	function automatic logic [31:0] pick_thr();
		case ($urandom_range(0, 3))
		0: return $urandom_range(0, 32767);
		1: return $urandom_range(0, 1) ? 32'd32767 : 32'd0;
		default: return $urandom_range(1, 3000);
		endcase
	endfunction

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 7))
		0: return $urandom_range(0, 65535);
		1: return 32'd0;
		default: return $urandom_range(1, 12);
		endcase
	endfunction

	// ---------------- bus tasks ----------------

	task automatic offer(msi_pkg::in_item_t ev, bit known, msi_pkg::out_item_t fixed);
		msi_pkg::out_item_t want;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= ev;
		do @(posedge clk); while (!in_ready);
		want = interlock_step(ev);
		status_q.push_back(known ? fixed : want);
		@(negedge clk);
	endtask

	// every result is back, so nothing is in flight
	task automatic drain();
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		msi_pkg::REG_STALL_PWM:   limits.stall_pwm_threshold   = val[14:0];
		msi_pkg::REG_STALL_SPEED: limits.stall_speed_threshold = val[14:0];
		msi_pkg::REG_OVERRUN_LIM: limits.overrun_limit         = val[15:0];
		msi_pkg::REG_LINE_LIM:    limits.line_lost_limit       = val[15:0];
		msi_pkg::REG_STALL_LIM:   limits.stall_limit           = val[15:0];
		default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(logic [31:0] pwm_thr, logic [31:0] speed_thr,
			logic [31:0] overrun_lim, logic [31:0] line_lim, logic [31:0] stall_lim);
		drain();
		reg_write(msi_pkg::REG_STALL_PWM, pwm_thr);
		reg_write(msi_pkg::REG_STALL_SPEED, speed_thr);
		reg_write(msi_pkg::REG_OVERRUN_LIM, overrun_lim);
		reg_write(msi_pkg::REG_LINE_LIM, line_lim);
		reg_write(msi_pkg::REG_STALL_LIM, stall_lim);
	endtask

	// ---------------- receiver ----------------

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				// long hold so the block backs up and drops in_ready
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_pending = 1'b0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// ---------------- main sequence ----------------

	initial begin
		int phase;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_item      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		fails        = 0;
		gaps_on      = 1'b1;
		stalls_on    = 1'b1;
		hold_pending = 1'b0;

		limits.stall_pwm_threshold   = 15'd0;
		limits.stall_speed_threshold = 15'd0;
		limits.overrun_limit         = 16'd3;
		limits.line_lost_limit       = 16'd150;
		limits.stall_limit           = 16'd300;
		track.line_lost_ticks   = 16'd0;
		track.left_stall_ticks  = 16'd0;
		track.right_stall_ticks = 16'd0;
		track.overrun_total     = 16'd0;
		track.latched_reason    = msi_pkg::REASON_BOOT;
		track.latched_fault     = msi_pkg::FLT_CLEAR;
		track.latched_tick      = 32'd0;

		// reset limits: speed threshold 0 means no stall can count
		add_ev(evt(msi_pkg::FUNC_ON_TIME, 32'd5, 1, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h0), 1'b1,
			status(0, 0, msi_pkg::REASON_BOOT, msi_pkg::FLT_CLEAR, 32'd0,
				16'd0, 16'd0, 16'd0, 16'd0));
		add_ev(evt(msi_pkg::FUNC_EVAL, 32'hFFFF_FFFF, 0, 1, 0, 16'h8000, 16'h7FFF, 16'h7FFF,
			16'h8000, 16'hFFFF), 1'b1,
			status(1, 1, msi_pkg::REASON_PARAM_ERROR, msi_pkg::FLT_LOGIC, 32'hFFFF_FFFF,
				16'd0, 16'd0, 16'd0, 16'd0));
		add_ev(evt(msi_pkg::FUNC_CLEAR_FAULT, 32'd0, 1, 1, 1, 16'hFFFF, 16'h0, 16'h0,
			16'hFFFF, 16'h0), 1'b1,
			status(0, 1, msi_pkg::REASON_NONE, msi_pkg::FLT_CLEAR, 32'd0,
				16'd0, 16'd0, 16'd0, 16'd0));
		// overrun ignored: zero missed ticks, then invalid parameters
		add_ev(evt(msi_pkg::FUNC_OVERRUN, 32'd1, 1, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h0), 1'b1,
			status(0, 0, msi_pkg::REASON_NONE, msi_pkg::FLT_CLEAR, 32'd0,
				16'd0, 16'd0, 16'd0, 16'd0));
		add_ev(evt(msi_pkg::FUNC_OVERRUN, 32'd2, 0, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'hFFFF), 1'b1,
			status(0, 0, msi_pkg::REASON_NONE, msi_pkg::FLT_CLEAR, 32'd0,
				16'd0, 16'd0, 16'd0, 16'd0));
		add_ev(evt(msi_pkg::FUNC_OVERRUN, 32'd7, 1, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'd2), 1'b1,
			status(0, 0, msi_pkg::REASON_NONE, msi_pkg::FLT_CLEAR, 32'd0,
				16'd0, 16'd0, 16'd0, 16'd2));
		add_ev(evt(msi_pkg::FUNC_OVERRUN, 32'd8, 1, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'd1), 1'b1,
			status(1, 1, msi_pkg::REASON_OVERRUN, msi_pkg::FLT_OVERRUN, 32'd8,
				16'd0, 16'd0, 16'd0, 16'd3));
		add_ev(evt(msi_pkg::FUNC_ON_TIME, 32'd3, 1, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h0));
		// overrun total saturates
		add_ev(evt(msi_pkg::FUNC_OVERRUN, 32'd9, 1, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'hFFFF), 1'b1,
			status(1, 1, msi_pkg::REASON_OVERRUN, msi_pkg::FLT_OVERRUN, 32'd9,
				16'd0, 16'd0, 16'd0, 16'hFFFF));
		add_ev(evt(msi_pkg::FUNC_OVERRUN, 32'd10, 1, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h8000));
		add_ev(evt(msi_pkg::FUNC_BEGIN_TRIAL, 32'h1234_5678, 1, 0, 0, 16'h0, 16'h0, 16'h0,
			16'h0, 16'h0), 1'b1,
			status(0, 0, msi_pkg::REASON_NONE, msi_pkg::FLT_CLEAR, 32'h1234_5678,
				16'd0, 16'd0, 16'd0, 16'd0));
		add_ev(evt(msi_pkg::FUNC_EVAL, 32'd20, 1, 1, 0, 16'h8000, 16'h7FFF, 16'h7FFF,
			16'h8000, 16'h0));
		add_ev(evt(msi_pkg::FUNC_EVAL, 32'd21, 1, 0, 0, 16'h8000, 16'h0, 16'h7FFF, 16'h0,
			16'h0));
		add_ev(evt(FUNC_SPARE_LO, 32'd22, 1, 1, 1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		add_ev(evt(FUNC_SPARE_HI, 32'd23, 0, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		// widest stall window, limits of one, overrun limit zero
		add_reg(msi_pkg::REG_STALL_PWM, 32'd0);
		add_reg(msi_pkg::REG_STALL_SPEED, 32'd32767);
		add_reg(msi_pkg::REG_OVERRUN_LIM, 32'd0);
		add_reg(msi_pkg::REG_LINE_LIM, 32'd1);
		add_reg(msi_pkg::REG_STALL_LIM, 32'd1);
		add_ev(evt(msi_pkg::FUNC_EVAL, 32'd30, 1, 0, 0, 16'h8000, 16'h0, 16'h7FFF, 16'h8000,
			16'h0));
		add_ev(evt(msi_pkg::FUNC_EVAL, 32'd31, 1, 0, 0, 16'h0, 16'h0, 16'hFFFF, 16'h7FFE,
			16'h0));
		add_ev(evt(msi_pkg::FUNC_EVAL, 32'd32, 1, 1, 0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		add_ev(evt(msi_pkg::FUNC_OVERRUN, 32'd33, 1, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'd1));
		add_ev(evt(msi_pkg::FUNC_EVAL, 32'd34, 1, 1, 1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		// zero limits: the compare always holds
		add_reg(msi_pkg::REG_LINE_LIM, 32'd0);
		add_reg(msi_pkg::REG_STALL_LIM, 32'd0);
		add_ev(evt(msi_pkg::FUNC_EVAL, 32'd40, 1, 1, 1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		add_ev(evt(msi_pkg::FUNC_EVAL, 32'd41, 1, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		add_ev(evt(msi_pkg::FUNC_CLEAR_FAULT, 32'hFFFF_FFFF, 1, 0, 0, 16'h0, 16'h0, 16'h0,
			16'h0, 16'h0), 1'b1,
			status(0, 1, msi_pkg::REASON_NONE, msi_pkg::FLT_CLEAR, 32'hFFFF_FFFF,
				16'd0, 16'd0, 16'd0, 16'd0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				reg_write(plan[i].idx, plan[i].val);
			end else begin
				offer(plan[i].ev, plan[i].known, plan[i].fixed);
			end
		end

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: set_config(32'd32767, 32'd32767, 32'd65535, 32'd65535, 32'd65535);
			1: set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
			2: set_config(32'd100, 32'd2000, 32'd1, 32'd1, 32'd1);
			default: set_config(pick_thr(), pick_thr(), pick_limit(), pick_limit(),
				pick_limit());
			endcase
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			if (phase == HOLD_PHASE) begin
				gaps_on      = 1'b0;
				hold_pending = 1'b1;
			end
			// no idling at all towards the end
			if (phase >= PHASES - 2) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end
			repeat (ITEMS_PER_PHASE) offer(random_event(), 1'b0, '0);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
